/* rtl/number_to_speech_tokens_top_assert.svh */
// Assertion macros used by nst_tokens in the number_to_speech_tokens RTL.
`ifndef NUMBER_TO_SPEECH_TOKENS_TOP_ASSERT_SVH
`define NUMBER_TO_SPEECH_TOKENS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define NST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define NST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/nst_pkg.sv */
// Types, constants and the decimal digit step shared by the number_to_speech_tokens RTL.
package nst_pkg;

  localparam int DEC_W = 17;

  localparam logic [1:0] CFG_THOUSAND = 2'd0;
  localparam logic [1:0] CFG_HUNDRED  = 2'd1;
  localparam logic [1:0] CFG_TEN      = 2'd2;

  localparam logic [7:0] ZERO_CHAR = 8'h30;

  typedef struct packed {
    logic       nz;
    logic [3:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] un;
  } nst_digits_t;

  typedef struct packed {
    logic [15:0] thousand;
    logic [15:0] hundred;
    logic [15:0] ten;
  } nst_words_t;

  typedef struct packed {
    logic [3:0]       q;
    logic [DEC_W-1:0] rem;
  } nst_dec_t;

  // Splits off one decimal digit by comparing against all nine multiples of the divisor.
  function automatic nst_dec_t dec_step(logic [DEC_W-1:0] v, logic [DEC_W-1:0] d);
    nst_dec_t         res;
    logic [DEC_W-1:0] kd;
    res.q   = '0;
    res.rem = v;
    for (int k = 1; k <= 9; k++) begin
      kd = DEC_W'(k) * d;
      if (v >= kd) begin
        res.q   = 4'(k);
        res.rem = v - kd;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/nst_digits.sv */
// Five-stage pipeline that registers the number and splits its low four decimal digits.
module nst_digits (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          in_number,
  output logic                 dg_valid,
  input  logic                 dg_ready,
  output nst_pkg::nst_digits_t dg
);

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                 rdy2, rdy3, rdy4, rdy5;
  logic [15:0]          num_r;
  logic [13:0]          r4_r;
  logic                 nz2_r, nz3_r, nz4_r;
  logic [9:0]           r3_r;
  logic [3:0]           th3_r, th4_r, hu4_r;
  logic [6:0]           r2_r;
  nst_pkg::nst_digits_t dg_r;
  nst_pkg::nst_dec_t    step2, step3, step4, step5;

  assign rdy5     = !v5_r || dg_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;

  assign step2 = nst_pkg::dec_step({1'b0, num_r}, nst_pkg::DEC_W'(10000));
  assign step3 = nst_pkg::dec_step(nst_pkg::DEC_W'(r4_r), nst_pkg::DEC_W'(1000));
  assign step4 = nst_pkg::dec_step(nst_pkg::DEC_W'(r3_r), nst_pkg::DEC_W'(100));
  assign step5 = nst_pkg::dec_step(nst_pkg::DEC_W'(r2_r), nst_pkg::DEC_W'(10));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) num_r <= in_number;
    if (rdy2 && v1_r) begin
      r4_r  <= step2.rem[13:0];
      nz2_r <= (num_r != 16'd0);
    end
    if (rdy3 && v2_r) begin
      th3_r <= step3.q;
      r3_r  <= step3.rem[9:0];
      nz3_r <= nz2_r;
    end
    if (rdy4 && v3_r) begin
      th4_r <= th3_r;
      hu4_r <= step4.q;
      r2_r  <= step4.rem[6:0];
      nz4_r <= nz3_r;
    end
    if (rdy5 && v4_r) begin
      dg_r.nz <= nz4_r;
      dg_r.th <= th4_r;
      dg_r.hu <= hu4_r;
      dg_r.te <= step5.q;
      dg_r.un <= step5.rem[3:0];
    end
  end

  assign dg_valid = v5_r;
  assign dg       = dg_r;

endmodule

/* rtl/nst_tokens.sv */
// Builds the byte slots of one number and sends the enabled ones, one byte per cycle while out_ready is high.
`include "number_to_speech_tokens_top_assert.svh"

module nst_tokens (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 dg_valid,
  output logic                 dg_ready,
  input  nst_pkg::nst_digits_t dg,
  input  nst_pkg::nst_words_t  words,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_byte
);

  localparam int NSLOT = 12;
  localparam logic [3:0] S_TH_D  = 4'd0;
  localparam logic [3:0] S_TW_HI = 4'd1;
  localparam logic [3:0] S_TW_LO = 4'd2;
  localparam logic [3:0] S_HU_D  = 4'd3;
  localparam logic [3:0] S_HW_HI = 4'd4;
  localparam logic [3:0] S_HW_LO = 4'd5;
  localparam logic [3:0] S_Z1    = 4'd6;
  localparam logic [3:0] S_TE_D  = 4'd7;
  localparam logic [3:0] S_TN_HI = 4'd8;
  localparam logic [3:0] S_TN_LO = 4'd9;
  localparam logic [3:0] S_Z2    = 4'd10;
  localparam logic [3:0] S_UN_D  = 4'd11;

  logic [NSLOT-1:0] mask_r, mask_nxt, new_mask, mask_rest;
  logic [7:0]       bytes_r [NSLOT];
  logic [7:0]       new_bytes [NSLOT];
  logic             t, h, e, u, single, load, take;
  logic [3:0]       sel;

  assign t = (dg.th != 4'd0);
  assign h = (dg.hu != 4'd0);
  assign e = (dg.te != 4'd0);
  assign u = (dg.un != 4'd0);

  always_comb begin
    new_bytes[S_TH_D]  = nst_pkg::ZERO_CHAR + {4'd0, dg.th};
    new_bytes[S_TW_HI] = words.thousand[15:8];
    new_bytes[S_TW_LO] = words.thousand[7:0];
    new_bytes[S_HU_D]  = nst_pkg::ZERO_CHAR + {4'd0, dg.hu};
    new_bytes[S_HW_HI] = words.hundred[15:8];
    new_bytes[S_HW_LO] = words.hundred[7:0];
    new_bytes[S_Z1]    = nst_pkg::ZERO_CHAR;
    new_bytes[S_TE_D]  = nst_pkg::ZERO_CHAR + {4'd0, dg.te};
    new_bytes[S_TN_HI] = words.ten[15:8];
    new_bytes[S_TN_LO] = words.ten[7:0];
    new_bytes[S_Z2]    = nst_pkg::ZERO_CHAR;
    new_bytes[S_UN_D]  = nst_pkg::ZERO_CHAR + {4'd0, dg.un};

    new_mask           = '0;
    new_mask[S_TH_D]   = t;
    new_mask[S_TW_HI]  = t && (words.thousand[15:8] != 8'd0);
    new_mask[S_TW_LO]  = t;
    new_mask[S_HU_D]   = h;
    new_mask[S_HW_HI]  = h && (words.hundred[15:8] != 8'd0);
    new_mask[S_HW_LO]  = h;
    new_mask[S_Z1]     = e && !h && t;
    new_mask[S_TE_D]   = e && !((dg.te == 4'd1) && !t && !h);
    new_mask[S_TN_HI]  = e && (words.ten[15:8] != 8'd0);
    new_mask[S_TN_LO]  = e;
    new_mask[S_Z2]     = u && !e && (t || h);
    new_mask[S_UN_D]   = u || !dg.nz;
  end

  always_comb begin
    sel = S_TH_D;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = 4'(i);
    end
  end

  assign mask_rest     = mask_r & (mask_r - NSLOT'(1));
  assign single        = (mask_rest == '0);
  assign out_valid     = (mask_r != '0);
  assign out_byte      = bytes_r[sel];
  assign out_last_byte = single;
  assign take          = out_valid && out_ready;
  assign dg_ready      = !out_valid || (take && single);
  assign load          = dg_valid && dg_ready;

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = new_mask;
    end else if (take) begin
      mask_nxt = mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NSLOT; i++) begin
        bytes_r[i] <= new_bytes[i];
      end
    end
  end

  `NST_ASSERT_NEXT(a_more_follow, clk, rst_n, take && !out_last_byte, out_valid, "bytes lost mid item")
  `NST_ASSERT_NEXT(a_load_shows, clk, rst_n, load && (new_mask != '0), out_valid, "loaded item not shown")
  `NST_ASSERT_SAME(a_hi_nonzero, clk, rst_n, out_valid && (sel == S_TW_HI || sel == S_HW_HI || sel == S_TN_HI), out_byte != 8'd0, "zero high byte sent")

endmodule

/* rtl/number_to_speech_tokens_top.sv */
// Top level of number_to_speech_tokens: configuration registers, digit pipeline and byte sender.
// Each number passes a five-stage digit pipeline (one item per cycle unless held by the byte
// sender) and then a byte sender that puts out one byte per cycle while out_ready is high,
// 1 to 10 bytes per number and none for a nonzero multiple of ten thousand; the first byte is
// offered once the item has passed the digit stages and been loaded into the byte slots, and
// the sustained rate is set by the byte count of each number; a number with no byte still loads.
module number_to_speech_tokens_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  nst_pkg::nst_words_t  words_r;
  nst_pkg::nst_digits_t dg;
  logic                 dg_valid, dg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nst_pkg::CFG_THOUSAND: words_r.thousand <= cfg_wdata;
        nst_pkg::CFG_HUNDRED:  words_r.hundred  <= cfg_wdata;
        nst_pkg::CFG_TEN:      words_r.ten      <= cfg_wdata;
        default: begin
          words_r <= words_r;
        end
      endcase
    end
  end

  nst_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_number(in_number),
    .dg_valid (dg_valid),
    .dg_ready (dg_ready),
    .dg       (dg)
  );

  nst_tokens u_tokens (
    .clk          (clk),
    .rst_n        (rst_n),
    .dg_valid     (dg_valid),
    .dg_ready     (dg_ready),
    .dg           (dg),
    .words        (words_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

endmodule

/* test/speech_token_checker.sv */
// Checker for number_to_speech_tokens_top: predicts the spoken byte stream and compares it.
module speech_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last_byte,
  input  logic        run_over,
  output int          mismatches,
  output int          bytes_pending,
  output int          bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } speech_byte_t;

  speech_byte_t expected_bytes[$];
  speech_byte_t oldest;
  logic [15:0]  thousand_code;
  logic [15:0]  hundred_code;
  logic [15:0]  ten_code;
  logic [7:0]   token_buf[16];
  int           token_count;
  bit           leftover_reported;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  function void add_token(input logic [15:0] code);
    if (code <= 16'h00FF) begin
      token_buf[token_count] = code[7:0];
      token_count++;
    end else begin
      token_buf[token_count]     = code[15:8];
      token_buf[token_count + 1] = code[7:0];
      token_count += 2;
    end
  endfunction

  function logic [15:0] digit_token(input int digit);
    return 16'(nst_pkg::ZERO_CHAR) + 16'(digit);
  endfunction

  function void spell_number(input logic [15:0] number);
    int n;
    int th;
    int hu;
    int te;
    int un;
    bit spoken;
    bit gap;
    n = int'(number);
    token_count = 0;
    spoken = 0;
    gap = 0;
    if (n == 0) begin
      add_token(digit_token(0));
    end else begin
      th = (n / 1000) % 10;
      hu = (n / 100) % 10;
      te = (n / 10) % 10;
      un = n % 10;
      if (th != 0) begin
        add_token(digit_token(th));
        add_token(thousand_code);
        spoken = 1;
      end
      if (hu != 0) begin
        if (gap) begin
          add_token(digit_token(0));
          gap = 0;
        end
        add_token(digit_token(hu));
        add_token(hundred_code);
        spoken = 1;
      end else if (spoken && (te != 0 || un != 0)) begin
        gap = 1;
      end
      if (te != 0) begin
        if (gap) begin
          add_token(digit_token(0));
          gap = 0;
        end
        // Ten to nineteen with nothing spoken before is read without the leading one.
        if (spoken || te != 1) add_token(digit_token(te));
        add_token(ten_code);
        spoken = 1;
      end else if (spoken && un != 0) begin
        gap = 1;
      end
      if (un != 0) begin
        if (gap) begin
          add_token(digit_token(0));
          gap = 0;
        end
        add_token(digit_token(un));
      end
    end
    for (int k = 0; k < token_count; k++) begin
      expected_bytes.push_back('{token_buf[k], k == token_count - 1});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bytes.delete();
      thousand_code = '0;
      hundred_code = '0;
      ten_code = '0;
      mismatches = 0;
      bytes_checked = 0;
      leftover_reported = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          nst_pkg::CFG_THOUSAND: thousand_code = cfg_wdata;
          nst_pkg::CFG_HUNDRED:  hundred_code = cfg_wdata;
          nst_pkg::CFG_TEN:      ten_code = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing expected", out_byte));
        end else begin
          oldest = expected_bytes.pop_front();
          if (out_byte !== oldest.value)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte, oldest.value));
          if (out_last_byte !== oldest.last)
            report_mismatch($sformatf("last flag %b on byte %02h, expected %b",
                                      out_last_byte, out_byte, oldest.last));
        end
        bytes_checked++;
      end
      if (in_valid && in_ready) spell_number(in_number);
      if (run_over && !leftover_reported) begin
        leftover_reported = 1;
        if (expected_bytes.size() != 0)
          report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end
    end
    bytes_pending <= expected_bytes.size();
  end

endmodule

/* test/number_to_speech_tokens_top_test.sv */
// Testbench top for number_to_speech_tokens_top: drives numbers and word codes, gives the verdict.
module number_to_speech_tokens_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 207;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 16;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_number;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        run_over;
  int          mismatches;
  int          bytes_pending;
  int          bytes_checked;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          numbers_sent;
  int          quiet_cycles;

  logic [15:0] directed_numbers[24] = '{
    16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd19, 16'd20, 16'd99,
    16'd100, 16'd101, 16'd110, 16'd1000, 16'd1001, 16'd1010, 16'd1100, 16'd1011,
    16'd5007, 16'd9999, 16'd10000, 16'd10012, 16'd10100, 16'd60000, 16'd65530, 16'd65535
  };

  number_to_speech_tokens_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte)
  );

  speech_token_checker byte_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte),
    .run_over     (run_over),
    .mismatches   (mismatches),
    .bytes_pending(bytes_pending),
    .bytes_checked(bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timed out with %0d bytes still expected", bytes_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int sparse_digit();
    return $urandom_range(1) ? int'($urandom_range(9, 1)) : 0;
  endfunction

  function automatic logic [15:0] random_number();
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 35) value = $urandom_range(65535);
    else if (pick < 50) value = $urandom_range(99);
    else if (pick < 60) value = 10000 * $urandom_range(5) + $urandom_range(19, 10);
    else if (pick < 68) value = 10000 * $urandom_range(6);
    else value = 10000 * $urandom_range(5) + 1000 * sparse_digit() + 100 * sparse_digit()
                 + 10 * sparse_digit() + sparse_digit();
    return 16'(value);
  endfunction

  task automatic send_number(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_number <= value;
    numbers_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_words(input logic [15:0] thousand, input logic [15:0] hundred,
                               input logic [15:0] ten);
    cfg_wr_en <= 1'b1;
    cfg_index <= nst_pkg::CFG_THOUSAND;
    cfg_wdata <= thousand;
    @(negedge clk);
    cfg_index <= nst_pkg::CFG_HUNDRED;
    cfg_wdata <= hundred;
    @(negedge clk);
    cfg_index <= nst_pkg::CFG_TEN;
    cfg_wdata <= ten;
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom_range(65535));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = nst_pkg::CFG_THOUSAND;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_number = '0;
    run_over = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 68;
    numbers_sent = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_words(16'h0000, 16'h00FF, 16'h0100);
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          program_words(16'hFFFF, 16'h0080, 16'h1234);
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 13;
          program_words(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        16'($urandom_range(65535)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          program_words(16'h00FF, 16'hFFFF, 16'h0000);
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        if (i == RANDOM_ITEMS / 6) drain_results();
        send_number(random_number());
      end
    end

    drain_results();
    run_over <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    $display("Spoke %0d numbers (%0d bytes checked) under four word-code settings,",
             numbers_sent, bytes_checked);
    $display("with sender-heavy, receiver-heavy and no idling.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
